// ===== rtl/kruskal_union_find_mst_cost_defines.svh =====
// assertion macros for the spanning tree cost engine
`ifndef KRUSKAL_UNION_FIND_MST_COST_DEFINES_SVH
`define KRUSKAL_UNION_FIND_MST_COST_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define KUF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KUF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kuf_pkg.sv =====
// shared types and constants for the spanning tree cost engine
package kuf_pkg;

   localparam int COUNT_W = 12;
   localparam int NODE_W  = 11;
   localparam int COST_W  = 31;
   localparam int TOTAL_W = 48;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef enum logic {
      CMD_CLEAR = 1'b0,
      CMD_EDGE  = 1'b1
   } cmd_type;

endpackage

// ===== rtl/kruskal_union_find_mst_cost.sv =====
// union-find engine for kruskal spanning tree cost, path halving on one parent memory
// a clear makes each node in use its own root; an edge with a bad endpoint goes straight to the result;
//    a valid edge walks both roots with path halving, then links them if the roots differ
// throughput: one beat at a time; the result beat shows as ready returns, a stalled result
//    holds the next item in the output state; each cycle reads the memory once and writes it at most once
// reset: synchronous; cost total and node count go to zero, parent memory holds until a clear
`include "kruskal_union_find_mst_cost_defines.svh"

module kruskal_union_find_mst_cost
   import kuf_pkg::*;
#(
   parameter int MAX_NODES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // node_count[11:0], node_a[22:12], node_b[33:23], edge_cost[64:34], zero fill
   input  logic [71:0] req_tdata,
   // cmd[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // total_cost[47:0]
   output logic [47:0] rsp_tdata,
   // joined[0], bad_node[1]
   output logic [1:0]  rsp_tuser
);

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CAP = (MAX_NODES > 4095) ? 4095 : MAX_NODES;
   localparam logic [COUNT_W-1:0] NODE_CAP = COUNT_W'(CAP);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_RD,
      S_CHK,
      S_HALF,
      S_LINK,
      S_OUT
   } state_type;

   // input fields
   logic [COUNT_W-1:0] in_count;
   logic [NODE_W-1:0]  in_a;
   logic [NODE_W-1:0]  in_b;
   logic [COST_W-1:0]  in_cost;
   logic               in_accept;
   logic [COUNT_W-1:0] clamp_count;

   // control and payload registers
   state_type          state_ff, state_in;
   logic               phase_ff, phase_in;
   logic [COUNT_W-1:0] sweep_ff, sweep_in;
   logic [COUNT_W-1:0] nodes_ff, nodes_in;
   logic [TOTAL_W-1:0] cost_sum_ff, cost_sum_in;
   logic [AW-1:0]      cur_ff, cur_in;
   logic [AW-1:0]      ra_ff, ra_in;
   logic [AW-1:0]      b_ff, b_in;
   logic [COST_W-1:0]  edge_cost_ff, edge_cost_in;
   logic               joined_ff, joined_in;
   logic               bad_ff, bad_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic               rsp_joined_ff, rsp_joined_in;
   logic               rsp_bad_ff, rsp_bad_in;

   // parent memory
   logic [AW-1:0]      parent_mem [MAX_NODES];
   logic [AW-1:0]      rdata_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_wdata;
   logic [AW-1:0]      mem_raddr;

   logic [TOTAL_W:0]   sum_wide;

   assign in_count  = req_tdata[11:0];
   assign in_a      = req_tdata[22:12];
   assign in_b      = req_tdata[33:23];
   assign in_cost   = req_tdata[64:34];
   assign req_tready = (state_ff == S_IDLE);
   assign in_accept = req_tvalid && req_tready;
   assign clamp_count = (in_count > NODE_CAP) ? NODE_CAP : in_count;

   assign sum_wide = {1'b0, cost_sum_ff} + (TOTAL_W + 1)'(edge_cost_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_total_ff;
   assign rsp_tuser  = {rsp_bad_ff, rsp_joined_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         parent_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= parent_mem[mem_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      sweep_in      = sweep_ff;
      nodes_in      = nodes_ff;
      cost_sum_in   = cost_sum_ff;
      cur_in        = cur_ff;
      ra_in         = ra_ff;
      b_in          = b_ff;
      edge_cost_in  = edge_cost_ff;
      joined_in     = joined_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_total_in  = rsp_total_ff;
      rsp_joined_in = rsp_joined_ff;
      rsp_bad_in    = rsp_bad_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_ff;
      mem_wdata     = rdata_ff;
      mem_raddr     = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (in_accept) begin
               joined_in = 1'b0;
               bad_in    = 1'b0;
               if (cmd_type'(req_tuser) == CMD_CLEAR) begin
                  nodes_in    = clamp_count;
                  cost_sum_in = '0;
                  sweep_in    = '0;
                  state_in    = (clamp_count == '0) ? S_OUT : S_CLEAR;
               end else if (({1'b0, in_a} >= nodes_ff) ||
                            ({1'b0, in_b} >= nodes_ff)) begin
                  bad_in   = 1'b1;
                  state_in = S_OUT;
               end else begin
                  cur_in       = AW'(in_a);
                  b_in         = AW'(in_b);
                  edge_cost_in = in_cost;
                  phase_in     = 1'b0;
                  state_in     = S_RD;
               end
            end
         end
         S_CLEAR: begin
            // each node in use becomes its own root, one entry a cycle
            mem_we    = 1'b1;
            mem_waddr = AW'(sweep_ff);
            mem_wdata = AW'(sweep_ff);
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff + 1'b1 == nodes_ff) begin
               state_in = S_OUT;
            end
         end
         S_RD: begin
            mem_raddr = cur_ff;
            state_in  = S_CHK;
         end
         S_CHK: begin
            if (rdata_ff == cur_ff) begin
               if (!phase_ff) begin
                  ra_in    = cur_ff;
                  cur_in   = b_ff;
                  phase_in = 1'b1;
                  state_in = S_RD;
               end else begin
                  state_in = S_LINK;
               end
            end else begin
               // fetch the grandparent
               mem_raddr = rdata_ff;
               state_in  = S_HALF;
            end
         end
         S_HALF: begin
            // point node at its grandparent and step there, reading its parent at once
            mem_we    = 1'b1;
            mem_waddr = cur_ff;
            mem_wdata = rdata_ff;
            mem_raddr = rdata_ff;
            cur_in    = rdata_ff;
            state_in  = S_CHK;
         end
         S_LINK: begin
            if (ra_ff != cur_ff) begin
               mem_we      = 1'b1;
               mem_waddr   = ra_ff;
               mem_wdata   = cur_ff;
               joined_in   = 1'b1;
               cost_sum_in = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_total_in  = cost_sum_ff;
               rsp_joined_in = joined_ff;
               rsp_bad_in    = bad_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nodes_ff     <= '0;
         cost_sum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nodes_ff     <= nodes_in;
         cost_sum_ff  <= cost_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff      <= phase_in;
      sweep_ff      <= sweep_in;
      cur_ff        <= cur_in;
      ra_ff         <= ra_in;
      b_ff          <= b_in;
      edge_cost_ff  <= edge_cost_in;
      joined_ff     <= joined_in;
      bad_ff        <= bad_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_joined_ff <= rsp_joined_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   `KUF_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, in_accept,
      state_ff != S_IDLE, "accepted beat did not start work")
   `KUF_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_valid_ff,
      !(rsp_joined_ff && rsp_bad_ff), "edge both joined and flagged")
   `KUF_ASSERT_NOW(a_halving_acyclic, clock, reset, state_ff == S_HALF,
      rdata_ff != cur_ff, "grandparent equals node during halving")
   `KUF_ASSERT_NEXT(a_cost_monotonic, clock, reset, state_ff == S_LINK,
      cost_sum_ff >= $past(cost_sum_ff), "running cost went down on link")
   `KUF_ASSERT_NOW(a_bad_keeps_cost, clock, reset, (state_ff == S_OUT) && bad_ff,
      !joined_ff, "flagged edge was joined")

endmodule
